// ===== rtl/nmea_gga_sentence_parser_defines.svh =====
// Assertion macros shared by the NMEA GGA parser RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef NMEA_GGA_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_GGA_SENTENCE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Implication or plain property, sampled on clk, off during reset
`define NGGA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Consequent checked in the cycle after the antecedent
`define NGGA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define NGGA_ASSERT(lbl, prop, msg)
`define NGGA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ngga_pkg.sv =====
// Types, constants and helpers for the NMEA GGA sentence parser.
// No dependencies; imported by every module of the block.
package ngga_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_FIELD_COUNT = 14;
	localparam int DEF_FIELD_CHARS = 16;

	// Field sizes of a queue item (cover the full parameter range)
	localparam int FIELD_W = 4;
	localparam int POS_W   = 5;

	// Depth of the queue between parser and store
	localparam int QUEUE_DEPTH = 4;

	// Opcodes
	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_C      = 8'h43;

	// Tag collection
	localparam logic [2:0] TAG_DEPTH = 3'd7;
	localparam logic [2:0] TAG_LAST  = 3'd6;
	localparam logic [2:0] TAG_POS_A = 3'd4;
	localparam logic [2:0] TAG_POS_B = 3'd5;

	// GGA field handling
	localparam logic [FIELD_W-1:0] FIELD_MAX   = 4'd15;
	localparam logic [FIELD_W-1:0] LAT_FIELD   = 4'd1;
	localparam int                 LAT_MARK_POS = 10;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_GGA  = 3'd1,
		KIND_GSA  = 3'd2,
		KIND_GSV  = 3'd3,
		KIND_RMC  = 3'd4
	} kind_t;

	// One item handed from the parser to the store side
	typedef struct packed {
		logic               op_read;
		logic               rd_zero;
		logic               wr_en;
		logic [FIELD_W-1:0] field;
		logic [POS_W-1:0]   pos;
		logic [7:0]         data;
		kind_t              kind;
		logic               in_sent;
		logic               seen;
	} q_entry_t;

	// Queue status toward both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Fields that hold one character: hemispheres, fix quality, unit letters
	function automatic logic single_char_field(logic [FIELD_W-1:0] f);
		return (f == 4'd2) || (f == 4'd4) || (f == 4'd5) || (f == 4'd9) ||
			(f == 4'd11) || (f == 4'd12);
	endfunction

	// Sentence kind from the fifth and sixth tag characters
	function automatic kind_t classify_tag(logic [7:0] c4, logic [7:0] c5);
		kind_t k;
		if (c4 == CH_G && c5 == CH_A)
			k = KIND_GGA;
		else if (c4 == CH_S && c5 == CH_A)
			k = KIND_GSA;
		else if (c5 == CH_V)
			k = KIND_GSV;
		else if (c5 == CH_C)
			k = KIND_RMC;
		else
			k = KIND_NONE;
		return k;
	endfunction

endpackage

// ===== rtl/ngga_front.sv =====
// Front end: accepts items, runs the sentence parser state, queues store work.
// Depends on ngga_pkg and nmea_gga_sentence_parser_defines.svh.
`include "nmea_gga_sentence_parser_defines.svh"
module ngga_front #(
	parameter int FIELD_COUNT = ngga_pkg::DEF_FIELD_COUNT,
	parameter int FIELD_CHARS = ngga_pkg::DEF_FIELD_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [7:0]          rx_byte,
	input  logic [3:0]          read_field,
	input  logic [3:0]          read_pos,
	input  ngga_pkg::q_status_t q_stat,
	output logic                push,
	output ngga_pkg::q_entry_t  push_entry
);
	import ngga_pkg::*;

	localparam int PW = $clog2(FIELD_CHARS + 1);

	logic               hunting_q, tag_done_q, seen_q;
	kind_t              kind_q;
	logic [2:0]         tag_count_q;
	logic [FIELD_W-1:0] field_q;
	logic [PW-1:0]      pos_q;
	logic [7:0]         tag4_q, tag5_q;

	logic               n_hunt, n_done, n_seen;
	kind_t              n_kind, cls;
	logic [2:0]         n_cnt;
	logic [FIELD_W-1:0] n_field;
	logic [PW-1:0]      n_pos, p_sel;
	logic [7:0]         n_tag4, n_tag5;
	logic               wr_en, rd_zero, accept;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign push     = accept;
	assign cls      = classify_tag(tag4_q, tag5_q);

	// Parser next state for one item
	always_comb begin
		n_hunt  = hunting_q;
		n_done  = tag_done_q;
		n_seen  = seen_q;
		n_kind  = kind_q;
		n_cnt   = tag_count_q;
		n_field = field_q;
		n_pos   = pos_q;
		n_tag4  = tag4_q;
		n_tag5  = tag5_q;
		p_sel   = pos_q;
		wr_en   = 1'b0;
		rd_zero = 1'b0;
		if (accept) begin
			if (opcode == OP_READ) begin
				rd_zero = !((read_field < FIELD_COUNT) && (read_pos < FIELD_CHARS));
			end else if (hunting_q) begin
				if (rx_byte == CH_DOLLAR) begin
					n_cnt   = 3'd1;
					n_hunt  = 1'b0;
					n_done  = 1'b0;
					n_kind  = KIND_NONE;
					n_field = '0;
					n_pos   = '0;
				end
			end else if (!tag_done_q) begin
				// collecting the tag
				priority if (rx_byte == CH_COMMA) begin
					n_kind  = cls;
					n_cnt   = 3'd0;
					n_field = '0;
					n_pos   = '0;
					if (cls == KIND_NONE)
						n_hunt = 1'b1;
					else
						n_done = 1'b1;
				end else if (rx_byte == CH_STAR) begin
					n_hunt = 1'b1;
				end else begin
					if (tag_count_q < TAG_DEPTH) begin
						if (tag_count_q == TAG_POS_A)
							n_tag4 = rx_byte;
						if (tag_count_q == TAG_POS_B)
							n_tag5 = rx_byte;
						n_cnt = tag_count_q + 3'd1;
					end
					if (n_cnt > TAG_LAST)
						n_hunt = 1'b1;
				end
			end else begin
				unique case (kind_q)
					KIND_GGA: begin
						priority if (rx_byte == CH_STAR) begin
							n_hunt = 1'b1;
						end else if (rx_byte == CH_COMMA) begin
							if (field_q != FIELD_MAX)
								n_field = field_q + 1'b1;
							n_pos = '0;
						end else begin
							p_sel = single_char_field(field_q) ? '0 : pos_q;
							if ((field_q < FIELD_COUNT) && (p_sel < FIELD_CHARS)) begin
								wr_en = 1'b1;
								if (field_q == LAT_FIELD && p_sel == PW'(LAT_MARK_POS))
									n_seen = 1'b1;
							end
							if (pos_q < FIELD_CHARS)
								n_pos = pos_q + PW'(1);
						end
					end
					KIND_GSA, KIND_GSV, KIND_RMC: begin
						if (rx_byte == CH_STAR)
							n_hunt = 1'b1;
					end
					default: begin
						// finished tag without a kind: drop back to hunting
						n_kind = KIND_NONE;
						n_done = 1'b0;
						n_cnt  = 3'd1;
						n_hunt = 1'b1;
					end
				endcase
			end
		end
	end

	// Item for the store side
	always_comb begin
		push_entry.op_read = (opcode == OP_READ);
		push_entry.rd_zero = rd_zero;
		push_entry.wr_en   = wr_en;
		push_entry.field   = (opcode == OP_READ) ? read_field : field_q;
		push_entry.pos     = (opcode == OP_READ) ? POS_W'(read_pos) : POS_W'(p_sel);
		push_entry.data    = rx_byte;
		push_entry.kind    = n_kind;
		push_entry.in_sent = !n_hunt;
		push_entry.seen    = n_seen;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q   <= 1'b1;
			tag_done_q  <= 1'b0;
			seen_q      <= 1'b0;
			kind_q      <= KIND_NONE;
			tag_count_q <= 3'd0;
			field_q     <= '0;
			pos_q       <= '0;
			tag4_q      <= 8'd0;
			tag5_q      <= 8'd0;
		end else begin
			hunting_q   <= n_hunt;
			tag_done_q  <= n_done;
			seen_q      <= n_seen;
			kind_q      <= n_kind;
			tag_count_q <= n_cnt;
			field_q     <= n_field;
			pos_q       <= n_pos;
			tag4_q      <= n_tag4;
			tag5_q      <= n_tag5;
		end
	end

	`NGGA_ASSERT(a_done_has_kind, tag_done_q |-> (kind_q != KIND_NONE), "tag done without kind")
	`NGGA_ASSERT(a_tag_count_live, (!hunting_q && !tag_done_q) |-> (tag_count_q != 3'd0 && tag_count_q != TAG_DEPTH), "tag count out of range while collecting")

endmodule

// ===== rtl/ngga_queue.sv =====
// Short FIFO of parser items between front end and store side.
// Depends on ngga_pkg and nmea_gga_sentence_parser_defines.svh.
`include "nmea_gga_sentence_parser_defines.svh"
module ngga_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ngga_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output ngga_pkg::q_entry_t  head,
	output ngga_pkg::q_status_t stat
);
	import ngga_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t         slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = slots_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));

	// Slot storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`NGGA_ASSERT(a_no_overflow, push |-> (!stat.full || pop), "push into full queue")
	`NGGA_ASSERT(a_no_underflow, pop |-> !stat.empty, "pop from empty queue")

endmodule

// ===== rtl/ngga_back.sv =====
// Store side: record memory, read-out and the registered result stage.
// Depends on ngga_pkg and nmea_gga_sentence_parser_defines.svh.
`include "nmea_gga_sentence_parser_defines.svh"
module ngga_back #(
	parameter int FIELD_COUNT = ngga_pkg::DEF_FIELD_COUNT,
	parameter int FIELD_CHARS = ngga_pkg::DEF_FIELD_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ngga_pkg::q_entry_t  head,
	input  ngga_pkg::q_status_t q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          read_char,
	output logic [2:0]          sentence_kind,
	output logic                in_sentence,
	output logic                location_seen,
	output logic                byte_stored
);
	import ngga_pkg::*;

	localparam int DEPTH = FIELD_COUNT * FIELD_CHARS;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] addr;
	logic          out_valid_q, show_q, stored_q, in_sent_q, seen_q;
	kind_t         kind_q;
	logic [7:0]    rdata_q;

	// Pop whenever the result register is free or being drained
	assign pop  = !q_stat.empty && (!out_valid_q || !out_stall);
	assign addr = AW'(32'(head.field) * FIELD_CHARS + 32'(head.pos));

	// Record memory, one access per item
	always_ff @(posedge clk) begin
		if (pop && head.wr_en)
			mem[addr] <= head.data;
		if (pop && head.op_read && !head.rd_zero)
			rdata_q <= mem[addr];
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			show_q    <= head.op_read && !head.rd_zero;
			stored_q  <= head.wr_en;
			in_sent_q <= head.in_sent;
			seen_q    <= head.seen;
			kind_q    <= head.kind;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign read_char     = show_q ? rdata_q : 8'd0;
	assign sentence_kind = kind_q;
	assign in_sentence   = in_sent_q;
	assign location_seen = seen_q;
	assign byte_stored   = stored_q;

	`NGGA_ASSERT(a_store_no_char, (out_valid_q && stored_q) |-> (read_char == 8'd0), "stored feed shows a character")
	`NGGA_ASSERT_NEXT(a_pop_gives_result, pop, out_valid_q, "popped item left no result")

endmodule

// ===== rtl/nmea_gga_sentence_parser.sv =====
// NMEA GGA sentence parser. Takes one item per clock unless in_stall is high: a received
// byte (opcode 0) or a read of one stored GGA character (opcode 1), and returns one result
// per item. The front end updates the parser state in the cycle an item is accepted and
// queues the store access; the store side performs it in the record memory, one access per
// cycle while the result register is free or being drained, and holds the result in an
// output register. A result passes through the queue and the output register before it is
// presented on the outputs; with no output stall items can be taken every cycle. Under an
// output stall the four-entry queue and the result register hold up to five items before
// in_stall is raised. Depends on ngga_pkg.
module nmea_gga_sentence_parser #(
	parameter int FIELD_COUNT = ngga_pkg::DEF_FIELD_COUNT,
	parameter int FIELD_CHARS = ngga_pkg::DEF_FIELD_CHARS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] rx_byte,
	input  logic [3:0] read_field,
	input  logic [3:0] read_pos,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_char,
	output logic [2:0] sentence_kind,
	output logic       in_sentence,
	output logic       location_seen,
	output logic       byte_stored
);
	import ngga_pkg::*;

	q_entry_t  push_entry, head;
	q_status_t q_stat;
	logic      push, pop;

	ngga_front #(
		.FIELD_COUNT(FIELD_COUNT),
		.FIELD_CHARS(FIELD_CHARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.rx_byte   (rx_byte),
		.read_field(read_field),
		.read_pos  (read_pos),
		.q_stat    (q_stat),
		.push      (push),
		.push_entry(push_entry)
	);

	ngga_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	ngga_back #(
		.FIELD_COUNT(FIELD_COUNT),
		.FIELD_CHARS(FIELD_CHARS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_char    (read_char),
		.sentence_kind(sentence_kind),
		.in_sentence  (in_sentence),
		.location_seen(location_seen),
		.byte_stored  (byte_stored)
	);

endmodule

// ===== dv/ngga_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the NMEA GGA sentence parser: watches both channels, predicts each result.
// Depends on ngga_pkg for the opcode, character and sentence kind definitions.
module ngga_checker #(
	parameter int FIELD_COUNT = ngga_pkg::DEF_FIELD_COUNT,
	parameter int FIELD_CHARS = ngga_pkg::DEF_FIELD_CHARS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] rx_byte,
	input  logic [3:0] read_field,
	input  logic [3:0] read_pos,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_char,
	input  logic [2:0] sentence_kind,
	input  logic       in_sentence,
	input  logic       location_seen,
	input  logic       byte_stored,
	output int         mismatches,
	output int         pending,
	output int         checked,
	output int         stored_total,
	output bit [FIELD_COUNT*FIELD_CHARS-1:0] written
);
	import ngga_pkg::*;

	localparam int STORE_DEPTH = FIELD_COUNT * FIELD_CHARS;
	localparam int POS_BITS    = $clog2(FIELD_CHARS + 1);
	localparam int TAG_SLOTS   = 7;
	// hemispheres, fix quality and unit letters: fields 2, 4, 5, 9, 11, 12
	localparam bit [15:0] ONE_CHAR_FIELDS = 16'h1A34;
	localparam logic [3:0] FIELD_CAP     = 4'd15;
	localparam logic [3:0] LAT_FIELD_IDX = 4'd1;
	localparam int         LAT_MARK_IDX  = 10;

	typedef struct packed {
		logic [7:0] ch;
		kind_t      kind;
		logic       in_sent;
		logic       seen;
		logic       stored;
	} gga_result_t;

	// Parser shadow state
	logic [7:0]          tag_chars [TAG_SLOTS];
	logic [2:0]          tag_len;
	logic                hunting;
	logic                tag_closed;
	kind_t               kind;
	logic [3:0]          field_idx;
	logic [POS_BITS-1:0] char_idx;
	logic                seen;
	logic [7:0]          char_store [STORE_DEPTH];

	gga_result_t due_results[$];

	// Kind from the fifth and sixth tag characters
	function automatic kind_t kind_of_tag(logic [7:0] c4, logic [7:0] c5);
		kind_t k;
		k = KIND_NONE;
		if (c5 == CH_A) begin
			if (c4 == CH_G)
				k = KIND_GGA;
			else if (c4 == CH_S)
				k = KIND_GSA;
		end else if (c5 == CH_V) begin
			k = KIND_GSV;
		end else if (c5 == CH_C) begin
			k = KIND_RMC;
		end
		return k;
	endfunction

	// Apply one item to the shadow state and form its result
	task automatic parse_item(input logic op, input logic [7:0] b, input logic [3:0] rf,
			input logic [3:0] rp, output gga_result_t r);
		int p;
		int slot;
		r = '0;
		if (op == OP_READ) begin
			if (rf < FIELD_COUNT && rp < FIELD_CHARS)
				r.ch = char_store[rf * FIELD_CHARS + rp];
		end else if (hunting) begin
			if (b == CH_DOLLAR) begin
				tag_chars[0] = CH_DOLLAR;
				tag_len = 3'd1;
				hunting = 1'b0;
				tag_closed = 1'b0;
				kind = KIND_NONE;
				field_idx = '0;
				char_idx = '0;
			end
		end else if (!tag_closed) begin
			// tag collection; stale slots 4 and 5 still count for short tags
			if (b == CH_COMMA) begin
				kind = kind_of_tag(tag_chars[4], tag_chars[5]);
				tag_len = '0;
				field_idx = '0;
				char_idx = '0;
				if (kind == KIND_NONE)
					hunting = 1'b1;
				else
					tag_closed = 1'b1;
			end else if (b == CH_STAR) begin
				hunting = 1'b1;
			end else begin
				if (tag_len < TAG_SLOTS) begin
					tag_chars[tag_len] = b;
					tag_len = tag_len + 3'd1;
				end
				if (tag_len > TAG_SLOTS - 1)
					hunting = 1'b1;
			end
		end else if (kind == KIND_GGA) begin
			if (b == CH_STAR) begin
				hunting = 1'b1;
			end else if (b == CH_COMMA) begin
				if (field_idx < FIELD_CAP)
					field_idx = field_idx + 4'd1;
				char_idx = '0;
			end else begin
				if (field_idx < FIELD_COUNT) begin
					p = ONE_CHAR_FIELDS[field_idx] ? 0 : int'(char_idx);
					if (p < FIELD_CHARS) begin
						slot = field_idx * FIELD_CHARS + p;
						char_store[slot] = b;
						written[slot] = 1'b1;
						r.stored = 1'b1;
						stored_total++;
						if (field_idx == LAT_FIELD_IDX && p == LAT_MARK_IDX)
							seen = 1'b1;
					end
				end
				if (char_idx < FIELD_CHARS)
					char_idx = char_idx + 1'b1;
			end
		end else if (kind == KIND_GSA || kind == KIND_GSV || kind == KIND_RMC) begin
			if (b == CH_STAR)
				hunting = 1'b1;
		end else begin
			// closed tag without a kind: drop back to hunting
			kind = KIND_NONE;
			tag_closed = 1'b0;
			tag_len = 3'd1;
			hunting = 1'b1;
		end
		r.kind = kind;
		r.in_sent = !hunting;
		r.seen = seen;
	endtask

	// Compare results in order, queue a prediction per accepted item
	always @(posedge clk or negedge arst_n) begin
		gga_result_t want;
		gga_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < TAG_SLOTS; i++)
				tag_chars[i] = '0;
			tag_len = '0;
			hunting = 1'b1;
			tag_closed = 1'b0;
			kind = KIND_NONE;
			field_idx = '0;
			char_idx = '0;
			seen = 1'b0;
			written = '0;
			due_results.delete();
			pending = 0;
			mismatches = 0;
			checked = 0;
			stored_total = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{read_char, kind_t'(sentence_kind), in_sentence, location_seen,
					byte_stored};
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, none pending: char %02h kind %0d",
						$time, read_char, sentence_kind);
				end else begin
					want = due_results.pop_front();
					checked++;
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected char %02h kind %0d in %0b seen %0b stored %0b",
							$time, want.ch, want.kind, want.in_sent, want.seen, want.stored);
						$display("%0t:   actual char %02h kind %0d in %0b seen %0b stored %0b",
							$time, got.ch, got.kind, got.in_sent, got.seen, got.stored);
					end
				end
			end
			if (in_valid && !in_stall) begin
				parse_item(opcode, rx_byte, read_field, read_pos, want);
				due_results.push_back(want);
			end
			pending = due_results.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the NMEA GGA parser testbench: clock, reset, sentence stimulus and verdict.
// Depends on ngga_pkg, the parser RTL and ngga_checker.
module tb_top;
	import ngga_pkg::*;

	localparam int FCNT         = DEF_FIELD_COUNT;
	localparam int FCH          = DEF_FIELD_CHARS;
	localparam int ITEM_TARGET  = 1900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 12;
	localparam int READ_PCT     = 12;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       opcode;
	logic [7:0] rx_byte;
	logic [3:0] read_field;
	logic [3:0] read_pos;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_char;
	logic [2:0] sentence_kind;
	logic       in_sentence;
	logic       location_seen;
	logic       byte_stored;

	int mismatches;
	int pending;
	int checked;
	int stored_total;
	bit [FCNT*FCH-1:0] written;

	int  tx_idle;
	int  rx_idle;
	bit  hold_req;
	int  hold_left;
	int  cycles;
	int  items_sent;
	int  gga_count;
	int  other_count;
	int  broken_count;
	logic [7:0] text_q[$];

	nmea_gga_sentence_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .rx_byte(rx_byte), .read_field(read_field), .read_pos(read_pos),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_char(read_char), .sentence_kind(sentence_kind), .in_sentence(in_sentence),
		.location_seen(location_seen), .byte_stored(byte_stored)
	);

	ngga_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .rx_byte(rx_byte), .read_field(read_field), .read_pos(read_pos),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_char(read_char), .sentence_kind(sentence_kind), .in_sentence(in_sentence),
		.location_seen(location_seen), .byte_stored(byte_stored),
		.mismatches(mismatches), .pending(pending), .checked(checked),
		.stored_total(stored_total), .written(written)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
		$display("** nmea_gga_sentence_parser: FAILED **");
		$finish;
	end

	// Result side: random stall, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle);
			end
		end
	end

	// Read address: a written entry, or one outside the store
	function automatic void pick_read(output logic [3:0] f, output logic [3:0] p);
		bit hit;
		int fi;
		int pi;
		hit = 1'b0;
		fi = 0;
		pi = 0;
		if ($urandom_range(9) != 0) begin
			for (int i = 0; i < 8 && !hit; i++) begin
				fi = $urandom_range(FCNT - 1);
				pi = $urandom_range(FCH - 1);
				hit = written[fi * FCH + pi];
			end
		end
		if (!hit) begin
			fi = $urandom_range(15, FCNT);
			pi = $urandom_range(15);
		end
		f = 4'(fi);
		p = 4'(pi);
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_item(input logic op, input logic [7:0] b, input logic [3:0] f,
			input logic [3:0] p, input bit counts, input bit pick);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		if (pick)
			pick_read(f, p);
		in_valid <= 1'b1;
		opcode <= op;
		rx_byte <= b;
		read_field <= f;
		read_pos <= p;
		do @(posedge clk); while (in_stall);
		if (counts)
			items_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	// Feed the queued text, with reads mixed in
	task automatic send_text(input bit counts, input int read_pct);
		logic [7:0] c;
		while (text_q.size() != 0) begin
			if ($urandom_range(99) < read_pct)
				send_item(OP_READ, 8'($urandom_range(255)), 4'd0, 4'd0, 1'b1, 1'b1);
			c = text_q.pop_front();
			send_item(OP_FEED, c, 4'($urandom_range(15)), 4'($urandom_range(15)), counts,
				1'b0);
		end
	endtask

	// Mostly digits, sometimes any byte that is not a separator
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		if ($urandom_range(4) != 0) begin
			c = 8'h30 + 8'($urandom_range(9));
		end else begin
			c = 8'($urandom_range(255));
			if (c == CH_COMMA || c == CH_STAR)
				c = 8'h2E;
		end
		return c;
	endfunction

	task automatic push_talker();
		text_q.push_back(8'h41 + 8'($urandom_range(25)));
		text_q.push_back(8'h41 + 8'($urandom_range(25)));
	endtask

	// Checksum and line end, seen while hunting
	task automatic send_trailer();
		string hex;
		hex = "0123456789ABCDEF";
		text_q.push_back(hex[$urandom_range(15)]);
		text_q.push_back(hex[$urandom_range(15)]);
		text_q.push_back(8'h0D);
		text_q.push_back(8'h0A);
		send_text(1'b0, 0);
	endtask

	// GGA sentence with random field lengths, overlong and extra fields now and then
	task automatic send_gga();
		int nf;
		int len;
		text_q.push_back(CH_DOLLAR);
		push_talker();
		push_str("GGA,");
		nf = ($urandom_range(5) == 0) ? $urandom_range(18, 1) : FCNT;
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				text_q.push_back(CH_COMMA);
			if (f inside {2, 4, 5, 9, 11, 12})
				len = $urandom_range(3);
			else if (f == 1)
				len = ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom_range(13, 11);
			else
				len = ($urandom_range(7) == 0) ? $urandom_range(20, 13) : $urandom_range(10);
			repeat (len)
				text_q.push_back(body_char());
		end
		// an unterminated sentence swallows whatever follows
		if ($urandom_range(11) != 0)
			text_q.push_back(CH_STAR);
		send_text(1'b1, READ_PCT);
		send_trailer();
		gga_count++;
	endtask

	// GSA, GSV or RMC: body is skipped up to the star
	task automatic send_other();
		int len;
		text_q.push_back(CH_DOLLAR);
		push_talker();
		case ($urandom_range(2))
			0: push_str("GSA,");
			1: push_str("GSV,");
			default: push_str("RMC,");
		endcase
		len = $urandom_range(30, 3);
		repeat (len)
			text_q.push_back(($urandom_range(4) == 0) ? CH_COMMA : body_char());
		text_q.push_back(CH_STAR);
		send_text(1'b1, READ_PCT);
		send_trailer();
		other_count++;
	endtask

	// Malformed starts: unknown tag, long tag, star in tag, short tag
	task automatic send_broken();
		case ($urandom_range(4))
			0: push_str("$GPXYZ,12,34*");
			1: begin
				if ($urandom_range(1) == 0)
					push_str("$GPGGAX,1,2*");
				else
					push_str("$$$$$$$9,");
			end
			2: push_str("$GP*1,");
			3: push_str("$GGA,");
			default: push_str("$GPQXA,5*");
		endcase
		repeat ($urandom_range(6))
			text_q.push_back(body_char());
		text_q.push_back(CH_STAR);
		send_text(1'b1, READ_PCT);
		broken_count++;
	endtask

	// Line noise between sentences, rarely a stray dollar
	task automatic send_noise();
		logic [7:0] c;
		repeat ($urandom_range(6, 1)) begin
			c = 8'($urandom_range(255));
			if (c == CH_DOLLAR && $urandom_range(3) != 0)
				c = 8'h0A;
			text_q.push_back(c);
		end
		send_text(1'b0, 0);
	endtask

	initial begin
		int base;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_FEED;
		rx_byte = '0;
		read_field = '0;
		read_pos = '0;
		hold_req = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		items_sent = 0;
		gga_count = 0;
		other_count = 0;
		broken_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme bytes, latitude mark, in-range and out-of-range reads
		send_item(OP_FEED, 8'h00, 4'h0, 4'h0, 1'b1, 1'b0);
		send_item(OP_FEED, 8'hFF, 4'hF, 4'hF, 1'b1, 1'b0);
		push_str("$GPGGA,,0123456789N*");
		send_text(1'b1, 0);
		send_item(OP_READ, 8'hFF, LAT_FIELD, 4'd10, 1'b1, 1'b0);
		send_item(OP_READ, 8'h00, 4'd14, 4'd0, 1'b1, 1'b0);
		send_item(OP_READ, 8'hA5, 4'd15, 4'd15, 1'b1, 1'b0);
		gga_count++;

		// Random sentences over three idling profiles
		base = items_sent;
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			tx_idle = (ph == 0) ? 19 : (ph == 1) ? 56 : 0;
			rx_idle = (ph == 0) ? 56 : (ph == 1) ? 19 : 0;
			hold_req = 1'b1;
			while (items_sent < base + (ph + 1) * ITEM_TARGET / 3) begin
				pick = $urandom_range(9);
				if (pick < 6)
					send_gga();
				else if (pick < 8)
					send_other();
				else if (pick < 9)
					send_broken();
				else
					send_noise();
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items: %0d GGA, %0d GSA/GSV/RMC, %0d malformed sentences",
			items_sent, gga_count, other_count, broken_count);
		$display("%0d results checked, %0d characters stored, location flag %0b",
			checked, stored_total, location_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("** nmea_gga_sentence_parser: PASSED **");
		end else begin
			$display("** nmea_gga_sentence_parser: FAILED **");
		end
		$finish;
	end

endmodule
